// File: rtl/thsc_pkg.sv
package thsc_pkg;

  localparam int MaxAttrDefault = 4;
  localparam int Channels       = 4;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 32;
  localparam int DistW          = 53;
  localparam int UW             = 25;

  localparam logic [CfgIdxW-1:0] CfgPpx   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPpy   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPpz   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgNx    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNy    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgNz    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgAttrN = 3'd6;

  typedef struct packed {
    logic signed [31:0] corner_x;
    logic signed [31:0] corner_y;
    logic signed [31:0] corner_z;
    logic signed [31:0] corner_attr_0;
    logic signed [31:0] corner_attr_1;
    logic signed [31:0] corner_attr_2;
    logic signed [31:0] corner_attr_3;
    logic [31:0]        source_cell;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        vertex_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_attr_0;
    logic signed [31:0] out_attr_1;
    logic signed [31:0] out_attr_2;
    logic signed [31:0] out_attr_3;
    logic [31:0]        out_cell;
    logic [2:0]         polygon_corners;
    logic               polygon_last;
  } out_item_t;

  // One vertex of a polygon: 7 values, flag for interpolation
  typedef struct packed {
    logic signed [6:0][31:0] va;
    logic signed [6:0][31:0] vb;
    logic                    interp;
    logic [DistW-1:0]        na;
    logic [DistW-1:0]        nb;
  } vtx_job_t;

  // A job carried through the queue: one vertex to produce
  typedef struct packed {
    vtx_job_t    v;
    logic [31:0] src_id;
    logic [2:0]  corners;
    logic        last;
    logic [2:0]  used;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_LERP,
    BK_OUT
  } bk_state_t;

endpackage

// File: rtl/thsc_front.sv
module thsc_front import thsc_pkg::*; #(
  parameter int MAX_ATTRIBUTES = MaxAttrDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  in_item_t            in_data,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                cfg_wr_en,
  output logic                job_valid,
  input  logic                job_ready,
  output job_t                job
);

  logic signed [31:0] ppx_r, ppy_r, ppz_r;
  logic signed [17:0] nx_r, ny_r, nz_r;
  logic [2:0]         attrn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppx_r <= '0; ppy_r <= '0; ppz_r <= '0;
      nx_r <= '0; ny_r <= '0; nz_r <= 18'sd65536;
      attrn_r <= 3'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CfgPpx:   ppx_r <= cfg_data;
        CfgPpy:   ppy_r <= cfg_data;
        CfgPpz:   ppz_r <= cfg_data;
        CfgNx:    nx_r <= cfg_data[17:0];
        CfgNy:    ny_r <= cfg_data[17:0];
        CfgNz:    nz_r <= cfg_data[17:0];
        CfgAttrN: attrn_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Front pipeline: stage A computes distance products (one per axis),
  // stage B sums them, classifies and lays out the polygon.
  logic               a_vld_r;
  in_item_t           a_item_r;
  logic signed [50:0] a_prod_r [3];
  logic [1:0]         phase_r;
  logic [1:0]         a_phase_r;

  logic signed [6:0][31:0] held_r [2];
  logic signed [DistW-1:0] hd_r [2];

  // polygon buffer drained one vertex per job
  vtx_job_t  poly_r [4];
  logic [2:0] pn_r, pi_r;
  logic [31:0] pcell_r;
  logic [2:0]  pused_r;
  logic        busy_r;

  logic accept;
  assign in_full = a_vld_r || busy_r;
  assign accept  = in_push && !in_full;

  logic signed [32:0] dx, dy, dz;
  assign dx = 33'(in_data.corner_x) - 33'(ppx_r);
  assign dy = 33'(in_data.corner_y) - 33'(ppy_r);
  assign dz = 33'(in_data.corner_z) - 33'(ppz_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item_r    <= in_data;
      a_prod_r[0] <= 51'(dx) * 51'(nx_r);
      a_prod_r[1] <= 51'(dy) * 51'(ny_r);
      a_prod_r[2] <= 51'(dz) * 51'(nz_r);
      a_phase_r   <= phase_r;
    end
  end

  logic signed [DistW-1:0] dsum;
  logic signed [6:0][31:0] cvals;
  assign dsum = DistW'(a_prod_r[0]) + DistW'(a_prod_r[1]) + DistW'(a_prod_r[2]);
  assign cvals = {a_item_r.corner_attr_3, a_item_r.corner_attr_2,
                  a_item_r.corner_attr_1, a_item_r.corner_attr_0,
                  a_item_r.corner_z, a_item_r.corner_y, a_item_r.corner_x};

  function automatic logic [DistW-1:0] fmag(logic signed [DistW-1:0] v);
    return v[DistW-1] ? DistW'(-v) : DistW'(v);
  endfunction

  // polygon layout
  logic signed [6:0][31:0] tv [3];
  logic signed [DistW-1:0] td [3];
  vtx_job_t  pl [4];
  logic [2:0] n;
  logic [2:0] used;
  always_comb begin
    tv[0] = held_r[0]; tv[1] = held_r[1]; tv[2] = cvals;
    td[0] = hd_r[0];   td[1] = hd_r[1];   td[2] = dsum;
    n = '0;
    for (int q = 0; q < 4; q++) pl[q] = '0;
    for (int i = 0; i < 3; i++) begin
      logic ka, kb;
      int b;
      b  = (i == 2) ? 0 : i + 1;
      ka = !td[i][DistW-1];
      kb = !td[b][DistW-1];
      if (ka && n < 3'd4) begin
        pl[n[1:0]].va = tv[i];
        pl[n[1:0]].interp = 1'b0;
        n = n + 3'd1;
      end
      if (ka != kb && n < 3'd4) begin
        pl[n[1:0]].va = tv[i];
        pl[n[1:0]].vb = tv[b];
        pl[n[1:0]].interp = 1'b1;
        pl[n[1:0]].na = fmag(td[i]);
        pl[n[1:0]].nb = fmag(td[b]);
        n = n + 3'd1;
      end
    end
    used = attrn_r;
    if (32'(used) > MAX_ATTRIBUTES) used = 3'(MAX_ATTRIBUTES);
    if (used > 3'(Channels)) used = 3'(Channels);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0; phase_r <= '0; busy_r <= 1'b0;
      pn_r <= '0; pi_r <= '0;
    end else begin
      if (accept) begin
        a_vld_r <= 1'b1;
        phase_r <= (phase_r == 2'd2) ? 2'd0 : phase_r + 2'd1;
      end else if (a_vld_r) begin
        a_vld_r <= 1'b0;
        if (a_phase_r != 2'd2) begin
          held_r[a_phase_r[0]] <= cvals;
          hd_r[a_phase_r[0]]   <= dsum;
        end else if (n >= 3'd3) begin
          busy_r  <= 1'b1;
          pn_r    <= n;
          pi_r    <= '0;
          pcell_r <= a_item_r.source_cell;
          pused_r <= used;
          for (int q = 0; q < 4; q++) poly_r[q] <= pl[q];
        end
      end
      if (busy_r && job_ready) begin
        pi_r <= pi_r + 3'd1;
        if (pi_r + 3'd1 == pn_r) busy_r <= 1'b0;
      end
    end
  end

  assign job_valid  = busy_r;
  assign job.v      = poly_r[pi_r[1:0]];
  assign job.src_id = pcell_r;
  assign job.corners = pn_r;
  assign job.last   = (pi_r + 3'd1 == pn_r);
  assign job.used   = pused_r;

endmodule

// File: rtl/thsc_queue.sv
module thsc_queue import thsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);

  // two-entry queue between front and back
  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job   = mem_r[rp_r];

  logic w, r;
  assign w = wr_valid && wr_ready;
  assign r = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (w) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (w) wp_r <= !wp_r;
      if (r) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(w) - 2'(r);
    end
  end

endmodule

// File: rtl/thsc_back.sv
module thsc_back import thsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  bk_state_t state_r, state_nxt;
  job_t      job_r;
  logic [DistW:0]   rem_r;
  logic [DistW:0]   den_r;
  logic [UW:0]      q_r;
  logic [4:0]       step_r;
  logic [2:0]       ch_r;
  logic [UW-1:0]    u_r;
  logic signed [6:0][31:0] res_r;
  logic [31:0]      vidx_r;
  out_item_t        obuf_r;
  logic             ovld_r;

  logic div_done, lerp_done, can_out;
  assign div_done  = step_r == 5'd26;
  assign lerp_done = ch_r == 3'd6;
  assign can_out   = !ovld_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (job_valid) state_nxt = job.v.interp ? BK_DIV : BK_OUT;
      BK_DIV:  if (div_done) state_nxt = BK_LERP;
      BK_LERP: if (lerp_done) state_nxt = BK_OUT;
      BK_OUT:  if (can_out) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign job_ready = state_r == BK_IDLE;

  // lerp datapath for one channel per cycle
  logic signed [32:0] diff;
  logic signed [58:0] prod;
  logic signed [34:0] rnd;
  logic signed [35:0] sum;
  logic signed [31:0] satv;
  assign diff = 33'($signed(job_r.v.vb[ch_r])) - 33'($signed(job_r.v.va[ch_r]));
  assign prod = 59'(diff) * $signed({1'b0, u_r});
  assign rnd  = 35'((prod + 59'sd8388608) >>> 24);
  assign sum  = 36'($signed(job_r.v.va[ch_r])) + 36'(rnd);
  always_comb begin
    if (sum > 36'sd2147483647) satv = 32'sh7fffffff;
    else if (sum < -36'sd2147483648) satv = 32'sh80000000;
    else satv = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ovld_r  <= 1'b0;
      vidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_OUT && can_out) begin
        ovld_r <= 1'b1;
        vidx_r <= vidx_r + 32'd1;
      end else if (out_pop && ovld_r) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        job_r  <= job;
        res_r  <= job.v.va;
        den_r  <= {1'b0, job.v.na} + {1'b0, job.v.nb};
        rem_r  <= {1'b0, job.v.na};
        q_r    <= '0;
        step_r <= '0;
        ch_r   <= '0;
      end
      BK_DIV: begin
        // first step compares unshifted, then 25 shift steps, then round
        if (step_r == 5'd0) begin
          if (rem_r >= den_r) begin
            q_r <= 26'd1; rem_r <= rem_r - den_r;
          end
        end else if (!div_done) begin
          if ({rem_r, 1'b0} >= {1'b0, den_r}) begin
            rem_r <= (DistW+1)'({rem_r, 1'b0} - {1'b0, den_r});
            q_r   <= {q_r[UW-1:0], 1'b1};
          end else begin
            rem_r <= {rem_r[DistW-1:0], 1'b0};
            q_r   <= {q_r[UW-1:0], 1'b0};
          end
        end
        step_r <= step_r + 5'd1;
        if (div_done) u_r <= UW'(({1'b0, q_r} + 27'd1) >> 1);
      end
      BK_LERP: begin
        res_r[ch_r] <= satv;
        ch_r <= ch_r + 3'd1;
      end
      default: ;
    endcase
    if (state_r == BK_OUT && can_out) begin
      obuf_r.vertex_index    <= vidx_r;
      obuf_r.out_x           <= res_r[0];
      obuf_r.out_y           <= res_r[1];
      obuf_r.out_z           <= res_r[2];
      obuf_r.out_attr_0      <= (job_r.used > 3'd0) ? res_r[3] : '0;
      obuf_r.out_attr_1      <= (job_r.used > 3'd1) ? res_r[4] : '0;
      obuf_r.out_attr_2      <= (job_r.used > 3'd2) ? res_r[5] : '0;
      obuf_r.out_attr_3      <= (job_r.used > 3'd3) ? res_r[6] : '0;
      obuf_r.out_cell        <= job_r.src_id;
      obuf_r.polygon_corners <= job_r.corners;
      obuf_r.polygon_last    <= job_r.last;
    end
  end

  assign out_empty = !ovld_r;
  assign out_data  = obuf_r;

endmodule

// File: rtl/triangle_half_space_clipper_unit.sv
// Clips each triangle (three corner beats) against the kept half-space of
// the configured plane and emits the 3 or 4 corners of the kept polygon as
// result beats with a running vertex index; nothing is emitted for a
// triangle fully outside. A front part computes corner distances (a new
// corner is taken only while stage B and the polygon buffer are free) and
// lays out the polygon; a back part, behind a two-entry queue, makes each
// vertex: a kept corner goes straight to output, an interpolated one first
// gets u (one unshifted compare, 25 shift-and-subtract steps and a rounding
// step), then one multiply per channel for 7 channels; output waits for a pop.
// Write configuration only while idle.
module triangle_half_space_clipper_unit import thsc_pkg::*; #(
  parameter int MAX_ATTRIBUTES = MaxAttrDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  in_item_t            in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output out_item_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic f_vld, f_rdy, b_vld, b_rdy;
  job_t f_job, b_job;

  thsc_front #(.MAX_ATTRIBUTES(MAX_ATTRIBUTES)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .cfg_index, .cfg_data, .cfg_wr_en,
    .job_valid(f_vld), .job_ready(f_rdy), .job(f_job)
  );

  thsc_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_vld), .wr_ready(f_rdy), .wr_job(f_job),
    .rd_valid(b_vld), .rd_ready(b_rdy), .rd_job(b_job)
  );

  thsc_back u_back (
    .clk, .rst_n,
    .job_valid(b_vld), .job_ready(b_rdy), .job(b_job),
    .out_empty, .out_pop, .out_data
  );

endmodule
